### hw/rtl/sfq_pkg.sv
// Shared types and codes for the slack-filling task queues.
// Used by the queue cell, the core and the port checker.
package sfq_pkg;

	localparam int NUM_CLASSES = 3;
	localparam logic [9:0] MS_TO_US = 10'd1000;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	localparam logic [1:0] CLASS_NONE = 2'd0;

	localparam logic [2:0] STAT_STORED   = 3'd0;
	localparam logic [2:0] STAT_REPLACED = 3'd1;
	localparam logic [2:0] STAT_DROPPED  = 3'd2;
	localparam logic [2:0] STAT_BAD      = 3'd3;
	localparam logic [2:0] STAT_FOUND    = 3'd4;
	localparam logic [2:0] STAT_NONE     = 3'd5;

	typedef struct packed {
		logic [15:0] wcet;
		logic [31:0] deadline;
		logic [2:0]  ctx;
		logic        rec;
		logic [7:0]  tid;
	} payload_t;

	typedef struct packed {
		logic     valid;
		payload_t pay;
	} entry_t;

	// one slot of each class queue, index 0 is the periodic queue
	typedef entry_t [NUM_CLASSES-1:0] row_t;

endpackage

### hw/rtl/slack_filling_task_queues_core.sv
// Slack-filling task queues: a ring of QUEUE_DEPTH cells rotated past one head.
// An insert makes one scan pass around the ring; a query makes a find pass and a pick
// step, then a clear pass when it hits; an insert with a bad class goes straight to the
// result. One item at a time, held off by in_stall until the result is registered: the
// next transfer can be taken in the cycle after that.
// Reset is asynchronous, active low, and empties every queue at once.
// Depends on sfq_pkg and sfq_cell.
module slack_filling_task_queues_core import sfq_pkg::*; #(
	parameter int QUEUE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [1:0]  task_class,
	input  logic [15:0] wcet_ms,
	input  logic [31:0] deadline_us,
	input  logic [2:0]  context_slot,
	input  logic        recovered_flag,
	input  logic [7:0]  task_id,
	input  logic [31:0] now_us,
	input  logic [15:0] slack_ms,
	input  logic [15:0] elapsed_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [1:0]  found_class,
	output logic [15:0] found_wcet_ms,
	output logic [31:0] found_deadline_us,
	output logic [2:0]  found_context,
	output logic        found_recovered,
	output logic [7:0]  found_task_id
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_PICK  = 3'd2;
	localparam logic [2:0] ST_CLEAR = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic             act_q;
	logic [1:0]       cls_q;
	payload_t         ins_q;
	logic [31:0]      now_q;
	logic [31:0]      thr_q;
	logic [15:0]      slack_q;
	logic             placed_q;
	logic [2:0]       stat_q;
	logic [NUM_CLASSES-1:0] hit_q;
	logic [NUM_CLASSES-1:0][IDX_W-1:0] hidx_q;
	payload_t [NUM_CLASSES-1:0] hdat_q;
	logic [1:0]       sel_q;
	logic [IDX_W-1:0] sel_idx_q;

	row_t cell_q [QUEUE_DEPTH];
	row_t head;
	row_t head_mod;
	logic shift;
	logic [NUM_CLASSES-1:0] match;
	logic [1:0] ins_k;
	logic place;
	logic in_acc;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign shift    = (state_q == ST_SCAN) || (state_q == ST_CLEAR);
	assign head     = cell_q[0];
	assign ins_k    = cls_q - 2'd1;

	always_comb begin
		for (int k = 0; k < NUM_CLASSES; k++) begin
			match[k] = head[k].valid && (head[k].pay.deadline > thr_q)
				&& ({16'd0, head[k].pay.wcet} < {16'd0, slack_q});
		end
		place = (state_q == ST_SCAN) && (act_q == ACT_INSERT) && !placed_q
			&& (!head[ins_k].valid || (head[ins_k].pay.deadline < now_q));
		head_mod = head;
		if (place) begin
			head_mod[ins_k].valid = 1'b1;
			head_mod[ins_k].pay   = ins_q;
		end
		if ((state_q == ST_CLEAR) && (idx_q == sel_idx_q)) begin
			head_mod[sel_q].valid = 1'b0;
		end
	end

	// the ring: each cell takes its neighbor, the last takes the edited head
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		row_t d;
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign d = head_mod;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		sfq_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.d     (d),
			.q     (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			placed_q  <= 1'b0;
			hit_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q    <= '0;
						placed_q <= 1'b0;
						hit_q    <= '0;
						if ((action == ACT_INSERT) && (task_class == CLASS_NONE)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (place) placed_q <= 1'b1;
					for (int k = 0; k < NUM_CLASSES; k++) begin
						if (match[k] && !hit_q[k]) hit_q[k] <= 1'b1;
					end
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= (act_q == ACT_INSERT) ? ST_FIN : ST_PICK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PICK: begin
					state_q <= (hit_q != '0) ? ST_CLEAR : ST_FIN;
				end
				ST_CLEAR: begin
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operands, search results and the output register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q         <= action;
			cls_q         <= task_class;
			ins_q.wcet    <= wcet_ms;
			ins_q.deadline <= deadline_us;
			ins_q.ctx     <= context_slot;
			ins_q.rec     <= recovered_flag;
			ins_q.tid     <= task_id;
			now_q         <= now_us;
			slack_q       <= slack_ms;
			thr_q         <= now_us + {6'd0, 26'(elapsed_ms) * 26'(MS_TO_US)};
			stat_q        <= (action == ACT_INSERT)
				? ((task_class == CLASS_NONE) ? STAT_BAD : STAT_DROPPED) : STAT_NONE;
		end
		if (place) stat_q <= head[ins_k].valid ? STAT_REPLACED : STAT_STORED;
		if (state_q == ST_SCAN) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				if (match[k] && !hit_q[k]) begin
					hidx_q[k] <= idx_q;
					hdat_q[k] <= head[k].pay;
				end
			end
		end
		if (state_q == ST_PICK) begin
			if (hit_q[0]) begin
				sel_q <= 2'd0; sel_idx_q <= hidx_q[0]; stat_q <= STAT_FOUND;
			end else if (hit_q[1]) begin
				sel_q <= 2'd1; sel_idx_q <= hidx_q[1]; stat_q <= STAT_FOUND;
			end else if (hit_q[2]) begin
				sel_q <= 2'd2; sel_idx_q <= hidx_q[2]; stat_q <= STAT_FOUND;
			end
		end
		if ((state_q == ST_FIN) && out_free) begin
			status <= stat_q;
			if (stat_q == STAT_FOUND) begin
				found_class       <= sel_q + 2'd1;
				found_wcet_ms     <= hdat_q[sel_q].wcet;
				found_deadline_us <= hdat_q[sel_q].deadline;
				found_context     <= hdat_q[sel_q].ctx;
				found_recovered   <= hdat_q[sel_q].rec;
				found_task_id     <= hdat_q[sel_q].tid;
			end else begin
				found_class       <= CLASS_NONE;
				found_wcet_ms     <= '0;
				found_deadline_us <= '0;
				found_context     <= '0;
				found_recovered   <= 1'b0;
				found_task_id     <= '0;
			end
		end
	end

endmodule

### hw/rtl/sfq_cell.sv
// One slot position of all three class queues in the shift ring.
// Depends on sfq_pkg for the entry types.
module sfq_cell import sfq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  row_t d,
	output row_t q
);

	logic     [NUM_CLASSES-1:0] vld_q;
	payload_t [NUM_CLASSES-1:0] pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (shift) begin
			for (int k = 0; k < NUM_CLASSES; k++) vld_q[k] <= d[k].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int k = 0; k < NUM_CLASSES; k++) pay_q[k] <= d[k].pay;
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_CLASSES; k++) begin
			q[k].valid = vld_q[k];
			q[k].pay   = pay_q[k];
		end
	end

endmodule

### hw/rtl/sfq_checker.sv
// Port-level checks for the slack-filling task queues, bound to the core.
// Depends on sfq_pkg for the status codes.
module sfq_checker import sfq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [1:0]  found_class,
	input logic [7:0]  found_task_id,
	input logic [15:0] found_wcet_ms
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result dropped while stalled");

	a_found_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_FOUND) |-> (found_class != CLASS_NONE))
		else $error("found result without a class");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_FOUND)
		|-> (found_class == CLASS_NONE) && (found_task_id == 8'd0)
			&& (found_wcet_ms == 16'd0))
		else $error("found fields set on a non-found result");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= STAT_NONE))
		else $error("status code out of range");

endmodule

bind slack_filling_task_queues_core sfq_checker u_sfq_checker (.*);

### test/sfq_port_checker.sv
// Port checker for the slack-filling task queues: watches both channels,
// keeps its own copy of the three class queues and compares every result.
// Depends on sfq_pkg.
module sfq_port_checker import sfq_pkg::*; #(
	parameter int QUEUE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [1:0]  task_class,
	input  logic [15:0] wcet_ms,
	input  logic [31:0] deadline_us,
	input  logic [2:0]  context_slot,
	input  logic        recovered_flag,
	input  logic [7:0]  task_id,
	input  logic [31:0] now_us,
	input  logic [15:0] slack_ms,
	input  logic [15:0] elapsed_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [1:0]  found_class,
	input  logic [15:0] found_wcet_ms,
	input  logic [31:0] found_deadline_us,
	input  logic [2:0]  found_context,
	input  logic        found_recovered,
	input  logic [7:0]  found_task_id,
	output int          mismatches,
	output int          pending,
	output int          tasks_stored,
	output int          slack_hits
);

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  cls;
		logic [15:0] wcet;
		logic [31:0] deadline;
		logic [2:0]  ctx;
		logic        rec;
		logic [7:0]  tid;
	} sched_result_t;

	bit            slot_used [NUM_CLASSES][QUEUE_DEPTH];
	payload_t      slot_pay  [NUM_CLASSES][QUEUE_DEPTH];
	sched_result_t due_results[$];

	task automatic schedule_item();
		sched_result_t r;
		logic [31:0]   thr;
		int            q;
		bit            done;
		r = '0;
		done = 0;
		if (action == ACT_INSERT) begin
			r.status = STAT_DROPPED;
			if (task_class == CLASS_NONE) begin
				r.status = STAT_BAD;
			end else begin
				q = task_class - 1;
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					if (!done && (!slot_used[q][i] || slot_pay[q][i].deadline < now_us)) begin
						r.status = slot_used[q][i] ? STAT_REPLACED : STAT_STORED;
						slot_used[q][i] = 1;
						slot_pay[q][i] = '{wcet_ms, deadline_us, context_slot,
							recovered_flag, task_id};
						done = 1;
						tasks_stored++;
					end
				end
			end
		end else begin
			r.status = STAT_NONE;
			thr = 32'(elapsed_ms) * 32'd1000 + now_us;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					if (!done && slot_used[c][i] && slot_pay[c][i].deadline > thr &&
							slot_pay[c][i].wcet < slack_ms) begin
						r = '{STAT_FOUND, 2'(c + 1), slot_pay[c][i].wcet,
							slot_pay[c][i].deadline, slot_pay[c][i].ctx,
							slot_pay[c][i].rec, slot_pay[c][i].tid};
						slot_used[c][i] = 0;
						done = 1;
						slack_hits++;
					end
				end
			end
		end
		due_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_result_t got, want;
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++)
				for (int i = 0; i < QUEUE_DEPTH; i++)
					slot_used[c][i] = 0;
			due_results.delete();
			mismatches = 0;
			tasks_stored = 0;
			slack_hits = 0;
		end else begin
			// results first: one landing here belongs to an earlier transfer
			if (out_valid && !out_stall) begin
				got = '{status, found_class, found_wcet_ms, found_deadline_us,
					found_context, found_recovered, found_task_id};
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected st=%0d cls=%0d wcet=%h dl=%h ctx=%0d rec=%0d id=%h, got st=%0d cls=%0d wcet=%h dl=%h ctx=%0d rec=%0d id=%h",
								want.status, want.cls, want.wcet, want.deadline,
								want.ctx, want.rec, want.tid, got.status, got.cls,
								got.wcet, got.deadline, got.ctx, got.rec, got.tid);
					end
				end
			end
			if (in_valid && !in_stall)
				schedule_item();
		end
		pending = due_results.size();
	end

endmodule

### test/slack_filling_task_queues_core_test.sv
// Top of the slack-filling task queue test: clock, reset, stimulus and verdict.
// Depends on sfq_pkg, sfq_port_checker and slack_filling_task_queues_core.
module slack_filling_task_queues_core_test import sfq_pkg::*;;

	typedef struct packed {
		logic        act;
		logic [1:0]  cls;
		logic [15:0] wcet;
		logic [31:0] deadline;
		logic [2:0]  ctx;
		logic        rec;
		logic [7:0]  tid;
		logic [31:0] now;
		logic [15:0] slack;
		logic [15:0] elapsed;
	} sched_item_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        action = 0;
	logic [1:0]  task_class = 0;
	logic [15:0] wcet_ms = 0;
	logic [31:0] deadline_us = 0;
	logic [2:0]  context_slot = 0;
	logic        recovered_flag = 0;
	logic [7:0]  task_id = 0;
	logic [31:0] now_us = 0;
	logic [15:0] slack_ms = 0;
	logic [15:0] elapsed_ms = 0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [2:0]  status;
	logic [1:0]  found_class;
	logic [15:0] found_wcet_ms;
	logic [31:0] found_deadline_us;
	logic [2:0]  found_context;
	logic        found_recovered;
	logic [7:0]  found_task_id;
	int          mismatches, pending, tasks_stored, slack_hits;
	int          idle_cycles = 0;
	int          items_sent = 0;
	bit          calm = 0;
	logic [31:0] time_base = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	slack_filling_task_queues_core #(.QUEUE_DEPTH(128)) DUT (.*);

	sfq_port_checker #(.QUEUE_DEPTH(128)) u_checker (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 5000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: hold stall for a drawn number of cycles before each transfer
	initial begin
		int n;
		@(posedge clk iff arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			forever begin
				@(negedge clk);
				if (out_valid) break;
			end
			@(posedge clk);
		end
	end

	task automatic send(input sched_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		action <= it.act;
		task_class <= it.cls;
		wcet_ms <= it.wcet;
		deadline_us <= it.deadline;
		context_slot <= it.ctx;
		recovered_flag <= it.rec;
		task_id <= it.tid;
		now_us <= it.now;
		slack_ms <= it.slack;
		elapsed_ms <= it.elapsed;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
		items_sent++;
	endtask

	function automatic sched_item_t random_item();
		sched_item_t it;
		it.act = ($urandom_range(0, 9) < 6) ? ACT_INSERT : ACT_QUERY;
		it.cls = ($urandom_range(0, 11) == 0) ? CLASS_NONE : 2'($urandom_range(1, 3));
		it.wcet = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200));
		it.deadline = $urandom_range(0, 3) == 0 ? $urandom
			: time_base + $urandom_range(0, 40000) - 32'd20000;
		it.ctx = 3'($urandom);
		it.rec = 1'($urandom);
		it.tid = 8'($urandom);
		it.now = $urandom_range(0, 15) == 0 ? $urandom
			: time_base + $urandom_range(0, 40000) - 32'd20000;
		it.slack = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 250));
		it.elapsed = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15));
		return it;
	endfunction

	initial begin
		sched_item_t it;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty query, bad class, field extremes, wrapped threshold
		send('{ACT_QUERY, 2'd1, 16'd0, 32'd0, 3'd0, 1'b0, 8'd0, 32'd0, 16'hffff, 16'd0});
		send('{ACT_INSERT, CLASS_NONE, 16'hffff, 32'hffffffff, 3'd7, 1'b1, 8'hff,
			32'd0, 16'd0, 16'd0});
		send('{ACT_INSERT, 2'd1, 16'd0, 32'hffffffff, 3'd7, 1'b1, 8'hff,
			32'hffffffff, 16'hffff, 16'hffff});
		send('{ACT_INSERT, 2'd2, 16'hffff, 32'd0, 3'd0, 1'b0, 8'd0, 32'd0, 16'd0, 16'd0});
		send('{ACT_INSERT, 2'd3, 16'd5, 32'd1000, 3'd3, 1'b1, 8'h5a, 32'd0, 16'd0, 16'd0});
		send('{ACT_QUERY, 2'd0, 16'd0, 32'd0, 3'd0, 1'b0, 8'd0, 32'd0, 16'd0, 16'd0});
		send('{ACT_QUERY, 2'd3, 16'hffff, 32'hffffffff, 3'd7, 1'b1, 8'hff,
			32'hffffffff, 16'hffff, 16'hffff});
		send('{ACT_INSERT, 2'd2, 16'd3, 32'd5, 3'd2, 1'b0, 8'h11, 32'd10, 16'd0, 16'd0});
		send('{ACT_INSERT, 2'd2, 16'd4, 32'd50, 3'd1, 1'b1, 8'h22, 32'd10, 16'd0, 16'd0});
		send('{ACT_QUERY, 2'd0, 16'd0, 32'd0, 3'd0, 1'b0, 8'd0, 32'd0, 16'd4, 16'd0});
		send('{ACT_QUERY, 2'd0, 16'd0, 32'd0, 3'd0, 1'b0, 8'd0, 32'd0, 16'd100, 16'd0});
		send('{ACT_QUERY, 2'd0, 16'd0, 32'd0, 3'd0, 1'b0, 8'd0, 32'd0, 16'd100, 16'd0});
		send('{ACT_QUERY, 2'd0, 16'd0, 32'd0, 3'd0, 1'b0, 8'd0, 32'd999, 16'd100, 16'd1});

		for (int n = 0; n < 250; n++) begin
			if ($urandom_range(0, 39) == 0) time_base = $urandom;
			send(random_item());
		end

		// fill the periodic queue past full, then drain part of it
		calm = 1;
		for (int n = 0; n < 140; n++) begin
			it = random_item();
			it.act = ACT_INSERT;
			it.cls = 2'd1;
			it.deadline = 32'hfffff000 + $urandom_range(0, 4095);
			it.now = $urandom_range(0, 1000);
			send(it);
		end
		calm = 0;
		for (int n = 0; n < 20; n++) begin
			it = random_item();
			it.act = ACT_QUERY;
			send(it);
		end

		time_base = 32'hffffc000;
		for (int n = 0; n < 290; n++) begin
			calm = (n >= 100 && n < 160);
			if ($urandom_range(0, 49) == 0) time_base = $urandom;
			send(random_item());
		end
		calm = 0;
		in_valid <= 0;

		forever begin
			@(posedge clk);
			if (pending == 0) break;
		end
		repeat (600) @(posedge clk);
		$display("%0d items sent: %0d tasks queued, %0d slack fills, all classes and full queue",
			items_sent, tasks_stored, slack_hits);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
